@@ rtl/gdc_pkg.sv @@
`timescale 1ns / 1ps
// gdc_pkg: shared constants, types and sequencer states of the grid ray caster.
// No dependencies; imported by the interfaces, the divider and the top level.
package gdc_pkg;

  // grid geometry
  localparam int MapSideDefault = 32;
  localparam int CellShift      = 6;
  localparam int WallLimit      = 127;
  localparam int StepLimit      = 8192;

  // field widths
  localparam int PosW   = 17;
  localparam int TrigW  = 18;
  localparam int CellW  = 8;
  localparam int DistW  = 31;
  localparam int EndW   = 19;
  localparam int RayW   = 20;
  localparam int ProdW  = 26;

  // divider widths; the divisor magnitude reaches 2^17 for a trig of -131072
  localparam int DivNumW = 36;
  localparam int DivMagW = 35;
  localparam int DivDenW = 18;
  localparam int DivShW  = DivDenW + DivMagW - 1;
  localparam int DivCntW = 6;
  localparam int DivWideIter  = 34;
  localparam int DivShortIter = 6;
  localparam int StepQW = DivShortIter + 1;

  localparam logic [DistW-1:0] NoHitDist = {DistW{1'b1}};

  // operation codes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_e;

  // face codes
  typedef enum logic [1:0] {
    FACE_EAST  = 2'd0,
    FACE_NORTH = 2'd1,
    FACE_WEST  = 2'd2,
    FACE_SOUTH = 2'd3
  } face_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_STEP_DIV,
    S_STEP_WAIT,
    S_READ,
    S_CHECK,
    S_DIST_WAIT,
    S_FINISH
  } state_e;

  // divider request
  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

endpackage

@@ rtl/gdc_if.sv @@
`timescale 1ns / 1ps
// gdc_in_if / gdc_out_if: valid/ready channels of the grid ray caster.
// Depends on gdc_pkg for the field widths.
interface gdc_in_if;
  import gdc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic signed [PosW-1:0]  pos_x;
  logic signed [PosW-1:0]  pos_y;
  logic signed [TrigW-1:0] sine;
  logic signed [TrigW-1:0] cosine;
  logic [CellW-1:0]        cell_value;

  modport source (output valid, operation, pos_x, pos_y, sine, cosine, cell_value,
                  input ready);
  modport sink (input valid, operation, pos_x, pos_y, sine, cosine, cell_value,
                output ready);
endinterface

interface gdc_out_if;
  import gdc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CellW-1:0]       cell_type;
  logic [1:0]             face;
  logic [CellShift-1:0]   offset;
  logic [DistW-1:0]       distance;
  logic signed [EndW-1:0] end_x;
  logic signed [EndW-1:0] end_y;

  modport source (output valid, cell_type, face, offset, distance, end_x, end_y,
                  input ready);
  modport sink (input valid, cell_type, face, offset, distance, end_x, end_y,
                output ready);
endinterface

@@ rtl/grid_ray_caster.sv @@
`timescale 1ns / 1ps
// grid_ray_caster: top level, map RAM, step sequencer and shared multiplier.
// Depends on gdc_pkg, gdc_if, gdc_ram and gdc_div.

// A write beat stores a cell. A cast beat walks the ray one grid line at a
// time: each step makes two passes of the shared multiplier, a 7-bit pass of
// the shared divider and a map RAM read, and a hit adds the 35-bit distance
// division in the same divider. The block takes one beat at a time; a
// finished result waits in the output register while the next beat is taken.
// After reset the map is cleared one cell per cycle, all MAP_SIDE*MAP_SIDE
// cells, and no beat is taken until that is done.
module grid_ray_caster #(
  parameter int MAP_SIDE = gdc_pkg::MapSideDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdc_in_if.sink    in_i,
  gdc_out_if.source out_o
);
  import gdc_pkg::*;

  localparam int Depth = MAP_SIDE * MAP_SIDE;
  localparam int AddrW = $clog2(Depth);
  localparam logic signed [RayW-1:0] Lim = RayW'(MAP_SIDE * (1 << CellShift));
  localparam logic [12:0] LastStep = 13'(StepLimit - 1);

  state_e state_q, state_d;

  logic [AddrW-1:0]        clr_q, clr_d;
  logic signed [RayW-1:0]  rx_q, rx_d, ry_q, ry_d;
  logic signed [RayW-1:0]  px_q, px_d, py_q, py_d;
  logic signed [TrigW-1:0] sn_q, sn_d, cs_q, cs_d;
  logic signed [ProdW-1:0] a_q, a_d, b_q, b_d;
  logic                    xstep_q, xstep_d;
  logic                    inb_q, inb_d;
  logic [12:0]             steps_q, steps_d;

  // result held until the output register is free
  logic [CellW-1:0]       res_cell_q, res_cell_d;
  logic [1:0]             res_face_q, res_face_d;
  logic [CellShift-1:0]   res_off_q, res_off_d;
  logic [DistW-1:0]       res_dist_q, res_dist_d;

  logic                   out_valid_q, out_valid_d;
  logic [CellW-1:0]       out_cell_q, out_cell_d;
  logic [1:0]             out_face_q, out_face_d;
  logic [CellShift-1:0]   out_off_q, out_off_d;
  logic [DistW-1:0]       out_dist_q, out_dist_d;
  logic signed [EndW-1:0] out_x_q, out_x_d, out_y_q, out_y_d;

  // map RAM port signals
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [CellW-1:0] ram_wdata, ram_rdata;

  // divider port signals
  div_req_t                div_req;
  logic signed [DivNumW-1:0] div_num;
  logic signed [TrigW-1:0]   div_den;
  logic                    div_done, div_neg;
  logic [DivMagW-1:0]      div_quo;

  // combinational helpers
  logic signed [7:0]       dx, dy;
  logic signed [7:0]       mul_l;
  logic signed [TrigW-1:0] mul_r;
  logic signed [ProdW-1:0] prod;
  logic [ProdW-1:0]        a_abs, b_abs;
  logic signed [RayW-1:0]  stepq;
  logic signed [RayW-1:0]  wx, wy, travel;
  logic                    in_acc, out_free;
  logic [CellW-1:0]        hit;
  logic                    leaving;
  logic [5:0]              lo;

  function automatic logic cell_inside(logic signed [RayW-1:0] x,
                                       logic signed [RayW-1:0] y);
    cell_inside = !x[RayW-1] && !y[RayW-1] && (x < Lim) && (y < Lim);
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(logic signed [RayW-1:0] x,
                                                 logic signed [RayW-1:0] y);
    logic [15:0] full;
    full = 16'(y[RayW-1:CellShift]) * 16'(MAP_SIDE) + 16'(x[RayW-1:CellShift]);
    cell_addr = full[AddrW-1:0];
  endfunction

  gdc_ram #(
    .Width (CellW),
    .Depth (Depth)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .neg_o      (div_neg),
    .quotient_o (div_quo)
  );

  // distances to the next grid lines and the shared multiplier
  always_comb begin
    dx = (cs_q > 0) ? 8'sd64 - $signed({2'b00, rx_q[5:0]})
                    : -8'sd1 - $signed({2'b00, rx_q[5:0]});
    dy = (sn_q > 0) ? 8'sd64 - $signed({2'b00, ry_q[5:0]})
                    : -8'sd1 - $signed({2'b00, ry_q[5:0]});
    mul_l = (state_q == S_MUL_B) ? dy : dx;
    mul_r = (state_q == S_MUL_B) ? cs_q : sn_q;
    prod  = ProdW'(mul_l * mul_r);
    a_abs = a_q[ProdW-1] ? ProdW'(-a_q) : ProdW'(a_q);
    b_abs = b_q[ProdW-1] ? ProdW'(-b_q) : ProdW'(b_q);
    stepq = div_neg ? -RayW'(div_quo[StepQW-1:0]) : RayW'(div_quo[StepQW-1:0]);
    wx    = RayW'(in_i.pos_x);
    wy    = RayW'(in_i.pos_y);
    travel = xstep_q ? rx_q - px_q : ry_q - py_q;
    hit   = inb_q ? ram_rdata : '0;
    leaving = (hit == '0) &&
              ((sn_q < 0 && ry_q < 0) || (sn_q > 0 && ry_q >= Lim) ||
               (cs_q < 0 && rx_q < 0) || (cs_q > 0 && rx_q >= Lim));
    lo    = xstep_q ? ry_q[5:0] : rx_q[5:0];
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // sequencer: next state and outputs
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    rx_d = rx_q;  ry_d = ry_q;  px_d = px_q;  py_d = py_q;
    sn_d = sn_q;  cs_d = cs_q;  a_d = a_q;    b_d = b_q;
    xstep_d = xstep_q;
    inb_d   = inb_q;
    steps_d = steps_q;
    res_cell_d = res_cell_q;
    res_face_d = res_face_q;
    res_off_d  = res_off_q;
    res_dist_d = res_dist_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_cell_d = out_cell_q;  out_face_d = out_face_q;  out_off_d = out_off_q;
    out_dist_d = out_dist_q;  out_x_d = out_x_q;        out_y_d = out_y_q;
    in_i.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cell_addr(wx, wy);
    ram_wdata = in_i.cell_value;
    ram_re    = 1'b0;
    ram_raddr = cell_addr(rx_q, ry_q);
    div_req   = '{start: 1'b0, wide: 1'b0};
    div_num   = DivNumW'(xstep_q ? a_q : b_q);
    div_den   = xstep_q ? cs_q : sn_q;

    unique case (state_q)
      // zero the map after reset
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      // take a beat
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_acc) begin
          if (in_i.operation == OP_WRITE) begin
            ram_we = cell_inside(wx, wy);
          end else begin
            px_d = wx;  py_d = wy;  rx_d = wx;  ry_d = wy;
            sn_d = in_i.sine;
            cs_d = in_i.cosine;
            steps_d = '0;
            if (in_i.sine == '0 && in_i.cosine == '0) begin
              res_cell_d = '0;
              res_face_d = FACE_EAST;
              res_off_d  = '0;
              res_dist_d = NoHitDist;
              state_d    = S_FINISH;
            end else begin
              state_d = S_MUL_A;
            end
          end
        end
      end
      S_MUL_A: begin
        a_d     = prod;
        state_d = S_MUL_B;
      end
      S_MUL_B: begin
        b_d     = prod;
        state_d = S_STEP_DIV;
      end
      // pick the nearer grid line and divide for the other axis
      S_STEP_DIV: begin
        xstep_d = a_abs < b_abs;
        div_num = DivNumW'((a_abs < b_abs) ? a_q : b_q);
        div_den = (a_abs < b_abs) ? cs_q : sn_q;
        div_req = '{start: 1'b1, wide: 1'b0};
        state_d = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        if (div_done) begin
          if (xstep_q) begin
            rx_d = rx_q + RayW'(dx);
            ry_d = ry_q + stepq;
          end else begin
            rx_d = rx_q + stepq;
            ry_d = ry_q + RayW'(dy);
          end
          state_d = S_READ;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        inb_d   = cell_inside(rx_q, ry_q);
        state_d = S_CHECK;
      end
      // wall, exit or next step
      S_CHECK: begin
        if (hit > CellW'(WallLimit)) begin
          res_cell_d = hit;
          if (xstep_q) begin
            res_face_d = (cs_q > 0) ? FACE_WEST : FACE_EAST;
            res_off_d  = (cs_q > 0) ? 6'd63 - lo : lo;
          end else begin
            res_face_d = (sn_q > 0) ? FACE_SOUTH : FACE_NORTH;
            res_off_d  = (sn_q > 0) ? lo : 6'd63 - lo;
          end
          div_num = {travel, 16'b0};
          div_den = xstep_q ? cs_q : sn_q;
          div_req = '{start: 1'b1, wide: 1'b1};
          state_d = S_DIST_WAIT;
        end else if (leaving || steps_q == LastStep) begin
          res_cell_d = '0;
          res_face_d = FACE_EAST;
          res_off_d  = '0;
          res_dist_d = NoHitDist;
          state_d    = S_FINISH;
        end else begin
          steps_d = steps_q + 1'b1;
          state_d = S_MUL_A;
        end
      end
      // saturate the distance
      S_DIST_WAIT: begin
        if (div_done) begin
          if (div_neg && div_quo != '0) begin
            res_dist_d = '0;
          end else if (div_quo[DivMagW-1:DistW] != '0) begin
            res_dist_d = NoHitDist;
          end else begin
            res_dist_d = div_quo[DistW-1:0];
          end
          state_d = S_FINISH;
        end
      end
      // hand over to the output register
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cell_d  = res_cell_q;
          out_face_d  = res_face_q;
          out_off_d   = res_off_q;
          out_dist_d  = res_dist_q;
          out_x_d     = rx_q[EndW-1:0];
          out_y_d     = ry_q[EndW-1:0];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rx_q <= rx_d;  ry_q <= ry_d;  px_q <= px_d;  py_q <= py_d;
    sn_q <= sn_d;  cs_q <= cs_d;  a_q <= a_d;    b_q <= b_d;
    xstep_q <= xstep_d;
    inb_q   <= inb_d;
    steps_q <= steps_d;
    res_cell_q <= res_cell_d;
    res_face_q <= res_face_d;
    res_off_q  <= res_off_d;
    res_dist_q <= res_dist_d;
    out_cell_q <= out_cell_d;
    out_face_q <= out_face_d;
    out_off_q  <= out_off_d;
    out_dist_q <= out_dist_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
  end

  // output beat
  assign out_o.valid     = out_valid_q;
  assign out_o.cell_type = out_cell_q;
  assign out_o.face      = out_face_q;
  assign out_o.offset    = out_off_q;
  assign out_o.distance  = out_dist_q;
  assign out_o.end_x     = out_x_q;
  assign out_o.end_y     = out_y_q;

endmodule

@@ rtl/gdc_ram.sv @@
`timescale 1ns / 1ps
// gdc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module gdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/gdc_div.sv @@
`timescale 1ns / 1ps
// gdc_div: shared restoring divider, one quotient bit per cycle, truncating sign.
// Depends on gdc_pkg; a short request gives 7 quotient bits, a wide one 35.
module gdc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gdc_pkg::div_req_t               req_i,
  input  logic signed [gdc_pkg::DivNumW-1:0] dividend_i,
  input  logic signed [gdc_pkg::TrigW-1:0]   divisor_i,
  output logic                            done_o,
  output logic                            neg_o,
  output logic [gdc_pkg::DivMagW-1:0]     quotient_o
);
  import gdc_pkg::*;

  logic [DivMagW-1:0] rem_q, rem_d;
  logic [DivShW-1:0]  dsh_q, dsh_d;
  logic [DivMagW-1:0] quo_q, quo_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               neg_q, neg_d;

  logic [DivNumW-1:0] num_abs;
  logic [TrigW-1:0]   den_abs;
  logic [DivShW-1:0]  rem_ext;
  logic               ge;

  // operand magnitudes
  always_comb begin
    num_abs = dividend_i[DivNumW-1] ? DivNumW'(-dividend_i) : DivNumW'(dividend_i);
    den_abs = divisor_i[TrigW-1] ? TrigW'(-divisor_i) : TrigW'(divisor_i);
    rem_ext = DivShW'(rem_q);
    ge      = rem_ext >= dsh_q;
  end

  // iteration control
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = num_abs[DivMagW-1:0];
      quo_d  = '0;
      neg_d  = dividend_i[DivNumW-1] ^ divisor_i[TrigW-1];
      busy_d = 1'b1;
      if (req_i.wide) begin
        dsh_d = DivShW'(den_abs[DivDenW-1:0]) << DivWideIter;
        cnt_d = DivCntW'(DivWideIter);
      end else begin
        dsh_d = DivShW'(den_abs[DivDenW-1:0]) << DivShortIter;
        cnt_d = DivCntW'(DivShortIter);
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q[DivMagW-1:0];
      end
      quo_d = {quo_q[DivMagW-2:0], ge};
      dsh_d = dsh_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign neg_o      = neg_q;
  assign quotient_o = quo_q;

endmodule
